### rtl/core/sjfb_pkg.sv
// Shared field widths and word types of the shortest-job-first batch scheduler.
package sjfb_pkg;

  localparam int TICK_W    = 16;
  localparam int JOB_NUM_W = 7;
  localparam int TIME_W    = 22;
  localparam int SUM_W     = 28;

  typedef struct packed {
    logic [TICK_W-1:0] arrival;
    logic [TICK_W-1:0] burst;
    logic              batch_end;
  } job_word_t;

  typedef struct packed {
    logic [JOB_NUM_W-1:0] job_number;
    logic [TIME_W-1:0]    finish_time;
    logic [TIME_W-1:0]    turnaround;
    logic [TIME_W-1:0]    wait_time;
    logic [SUM_W-1:0]     turnaround_sum;
    logic [SUM_W-1:0]     wait_sum;
    logic                 final_result;
    logic                 dropped;
  } result_word_t;

  typedef struct packed {
    logic [JOB_NUM_W-1:0] number;
    logic [TICK_W-1:0]    arrival;
    logic [TICK_W-1:0]    burst;
    logic                 keep;
    logic                 batch_end;
    logic                 dropped;
  } queue_word_t;

endpackage

### rtl/core/sjfb_front.sv
// Front end: numbers incoming jobs, drops those beyond capacity and queues the rest.
module sjfb_front import sjfb_pkg::*; #(
  parameter int JOBS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_word_t   job,
  output logic        q_valid,
  input  logic        q_ready,
  output queue_word_t q
);

  localparam int CNT_W = $clog2(JOBS + 1);

  logic [CNT_W-1:0] loaded_count;
  logic             overflow_seen;
  logic             full;
  logic             accept;

  assign full      = (loaded_count == CNT_W'(JOBS));
  assign job_ready = q_ready;
  assign accept    = job_valid && job_ready;

  assign q_valid     = job_valid && (!full || job.batch_end);
  assign q.number    = JOB_NUM_W'(loaded_count) + JOB_NUM_W'(1);
  assign q.arrival   = job.arrival;
  assign q.burst     = job.burst;
  assign q.keep      = !full;
  assign q.batch_end = job.batch_end;
  assign q.dropped   = overflow_seen || full;

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count  <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (job.batch_end) begin
        loaded_count  <= '0;
        overflow_seen <= 1'b0;
      end else begin
        if (!full) begin
          loaded_count <= loaded_count + CNT_W'(1);
        end
        overflow_seen <= overflow_seen || full;
      end
    end
  end

endmodule

### rtl/core/sjfb_queue.sv
// Two-entry queue between the front end and the sorting back end.
module sjfb_queue import sjfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  output logic        push_ready,
  input  queue_word_t push_word,
  output logic        pop_valid,
  input  logic        pop_ready,
  output queue_word_t pop_word
);

  queue_word_t entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic        push;
  logic        pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_word   = entry[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

### rtl/core/sjfb_back.sv
// Back end: insertion sort chain ordered by burst, then the result pipeline.
module sjfb_back import sjfb_pkg::*; #(
  parameter int JOBS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  output logic         q_ready,
  input  queue_word_t  q,
  output logic         result_valid,
  input  logic         result_ready,
  output result_word_t result
);

  localparam int CNT_W = $clog2(JOBS + 1);

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } back_state_t;

  typedef struct packed {
    logic [JOB_NUM_W-1:0] number;
    logic [TICK_W-1:0]    arrival;
    logic [TICK_W-1:0]    burst;
  } cell_t;

  function automatic logic [TIME_W-1:0] abs_diff(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  back_state_t      state;
  logic [CNT_W-1:0] count;
  logic             emit_first;
  logic             batch_drop;

  cell_t            cells     [JOBS];
  cell_t            prev_cell [JOBS];
  cell_t            next_cell [JOBS];
  cell_t            new_cell;
  logic [JOBS-1:0]  gt;
  logic [JOBS-1:0]  from_prev;
  logic [JOBS-1:0]  take_new;

  logic             advance;
  logic             ins;
  logic             pop;
  logic [TIME_W-1:0] pop_finish;
  logic [TIME_W-1:0] running_finish;

  logic                 s1_valid;
  logic [JOB_NUM_W-1:0] s1_number;
  logic [TICK_W-1:0]    s1_arrival;
  logic [TICK_W-1:0]    s1_burst;
  logic [TIME_W-1:0]    s1_finish;
  logic                 s1_first;
  logic                 s1_last;
  logic                 s1_drop;

  logic                 s2_valid;
  logic [JOB_NUM_W-1:0] s2_number;
  logic [TICK_W-1:0]    s2_burst;
  logic [TIME_W-1:0]    s2_finish;
  logic [TIME_W-1:0]    s2_ta;
  logic                 s2_first;
  logic                 s2_last;
  logic                 s2_drop;

  logic [TIME_W-1:0] out_wt;
  logic [SUM_W-1:0]  tsum_next;
  logic [SUM_W-1:0]  wsum_next;
  logic [SUM_W-1:0]  sum_turnaround;
  logic [SUM_W-1:0]  sum_wait;

  assign advance = !result_valid || result_ready;
  assign q_ready = (state == ST_LOAD);
  assign ins     = (state == ST_LOAD) && q_valid && q.keep;
  assign pop     = (state == ST_EMIT) && advance;

  assign new_cell.number  = q.number;
  assign new_cell.arrival = q.arrival;
  assign new_cell.burst   = q.burst;

  for (genvar g = 0; g < JOBS; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign prev_cell[g] = '0;
      assign from_prev[g] = 1'b0;
    end else begin : g_rest
      assign prev_cell[g] = cells[g-1];
      assign from_prev[g] = gt[g-1];
    end
    if (g == JOBS - 1) begin : g_tail
      assign next_cell[g] = '0;
    end else begin : g_body
      assign next_cell[g] = cells[g+1];
    end

    assign gt[g]       = (CNT_W'(g) < count) && (cells[g].burst > q.burst);
    assign take_new[g] = !from_prev[g] && (gt[g] || (CNT_W'(g) == count));

    always_ff @(posedge clk) begin
      if (ins) begin
        if (from_prev[g]) begin
          cells[g] <= prev_cell[g];
        end else if (take_new[g]) begin
          cells[g] <= new_cell;
        end
      end else if (pop) begin
        cells[g] <= next_cell[g];
      end
    end
  end

  assign pop_finish = (emit_first ? '0 : running_finish) + TIME_W'(cells[0].burst);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      count      <= '0;
      emit_first <= 1'b0;
      batch_drop <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (q_valid) begin
            if (q.keep) begin
              count <= count + CNT_W'(1);
            end
            if (q.batch_end) begin
              state      <= ST_EMIT;
              emit_first <= 1'b1;
              batch_drop <= q.dropped;
            end
          end
        end
        ST_EMIT: begin
          if (advance) begin
            count      <= count - CNT_W'(1);
            emit_first <= 1'b0;
            if (count == CNT_W'(1)) begin
              state <= ST_LOAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  always_comb begin
    out_wt    = abs_diff(s2_ta, TIME_W'(s2_burst));
    tsum_next = (s2_first ? '0 : sum_turnaround) + SUM_W'(s2_ta);
    wsum_next = (s2_first ? '0 : sum_wait) + SUM_W'(out_wt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      s2_valid       <= 1'b0;
      result_valid   <= 1'b0;
      running_finish <= '0;
      sum_turnaround <= '0;
      sum_wait       <= '0;
    end else if (advance) begin
      s1_valid     <= pop;
      s2_valid     <= s1_valid;
      result_valid <= s2_valid;
      if (pop) begin
        running_finish <= pop_finish;
      end
      if (s2_valid) begin
        sum_turnaround <= tsum_next;
        sum_wait       <= wsum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (pop) begin
        s1_number  <= cells[0].number;
        s1_arrival <= cells[0].arrival;
        s1_burst   <= cells[0].burst;
        s1_finish  <= pop_finish;
        s1_first   <= emit_first;
        s1_last    <= (count == CNT_W'(1));
        s1_drop    <= batch_drop;
      end
      if (s1_valid) begin
        s2_number <= s1_number;
        s2_burst  <= s1_burst;
        s2_finish <= s1_finish;
        s2_ta     <= abs_diff(s1_finish, TIME_W'(s1_arrival));
        s2_first  <= s1_first;
        s2_last   <= s1_last;
        s2_drop   <= s1_drop;
      end
      if (s2_valid) begin
        result.job_number     <= s2_number;
        result.finish_time    <= s2_finish;
        result.turnaround     <= s2_ta;
        result.wait_time      <= out_wt;
        result.turnaround_sum <= s2_last ? tsum_next : '0;
        result.wait_sum       <= s2_last ? wsum_next : '0;
        result.final_result   <= s2_last;
        result.dropped        <= s2_drop;
      end
    end
  end

endmodule

### rtl/core/shortest_job_first_batch.sv
// Top level of the shortest-job-first batch scheduler.
//
// Jobs are taken one per cycle while the back end is loading; each is
// inserted into a sorting chain of JOBS cells ordered by burst, equal bursts
// keeping their load order, and jobs beyond JOBS are discarded and flagged.
// The word that closes the batch switches the chain to draining, after which
// the chain is drained one result per cycle while result_ready allows, each
// result passing through stages s1 and s2 and the result register. While a
// batch drains, the next batch's first two jobs wait in the queue behind the
// front end; the chain takes no new job until the last job of the current
// batch has left it. There is no clearing pass.
module shortest_job_first_batch import sjfb_pkg::*; #(
  parameter int JOBS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         job_valid,
  output logic         job_ready,
  input  job_word_t    job,
  output logic         result_valid,
  input  logic         result_ready,
  output result_word_t result
);

  logic        push_valid;
  logic        push_ready;
  queue_word_t push_word;
  logic        pop_valid;
  logic        pop_ready;
  queue_word_t pop_word;

  sjfb_front #(.JOBS(JOBS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .q_valid   (push_valid),
    .q_ready   (push_ready),
    .q         (push_word)
  );

  sjfb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_word   (pop_word)
  );

  sjfb_back #(.JOBS(JOBS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (pop_valid),
    .q_ready      (pop_ready),
    .q            (pop_word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  a_number_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.job_number != '0) &&
                     (result.job_number <= JOB_NUM_W'(JOBS)))
    else $error("job number outside the loaded range");

  a_finish_rises: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !result.final_result |=>
      !result_valid || (result.finish_time >= $past(result.finish_time)))
    else $error("finish time fell within a batch");

  a_drop_steady: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !result.final_result |=>
      !result_valid || (result.dropped == $past(result.dropped)))
    else $error("dropped flag changed within a batch");

  a_totals_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.final_result |->
      (result.turnaround_sum == '0) && (result.wait_sum == '0))
    else $error("batch totals on a word that is not the last");

endmodule
